### sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PWR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define PWR_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);
`else
`define PWR_ASSERT(lbl, clk, rstn, prop)
`define PWR_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif

`endif

### sv/pwr_pkg.sv
`timescale 1ns / 1ps
package pwr_pkg;

  localparam int UNIT_FRAC = 30;
  localparam int COEF_FRAC = 16;
  localparam int COEF_W    = 17;
  localparam int QB        = UNIT_FRAC + 1;
  localparam int UB        = QB + 1;

  localparam logic [COEF_W-1:0]      COEF_ONE   = 17'h10000;
  localparam logic signed [COEF_W:0] COEF_ONE_S = 18'sh10000;

  typedef enum logic {
    CFG_NORMAL     = 1'b0,
    CFG_TANGENTIAL = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic into;
    logic zero;
  } pwr_ctl_t;

endpackage

### sv/pwr_sqrt.sv
`timescale 1ns / 1ps
module pwr_sqrt
  import pwr_pkg::*;
#(
  parameter int W = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [2*W+1:0]   s_i,
  output logic [W:0]       root_o
);

  localparam int SW = 2 * W + 2;
  localparam int N  = W + 1;
  localparam int RW = W + 3;

  logic [RW-1:0] rem_q  [N];
  logic [W:0]    root_q [N];
  logic [SW-1:0] x_q    [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] rin, r2, trial;
    logic [W:0]    qin;
    logic [SW-1:0] xin;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign xin = s_i;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
      assign xin = x_q[k-1];
    end

    assign r2    = {rin[RW-3:0], xin[SW-1:SW-2]};
    assign trial = {qin, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (r2 - trial) : r2;
        root_q[k] <= {qin[W-1:0], ge};
        x_q[k]    <= {xin[SW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

### sv/pwr_lane_div.sv
`timescale 1ns / 1ps
module pwr_lane_div
  import pwr_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [W-1:0]           a_i,
  input  logic                   neg_i,
  input  logic signed [W-1:0]    v_i,
  input  logic [W:0]             m_i,
  output logic signed [UB-1:0]   u_o,
  output logic signed [W-1:0]    v_o,
  output logic signed [W+UB-1:0] prod_o
);

  localparam int RW = W + 2;

  logic [RW-1:0]        rem_q [QB];
  logic [QB-1:0]        q_q   [QB];
  logic [QB-1:0]        x_q   [QB];
  logic [W:0]           m_q   [QB];
  logic                 neg_q [QB];
  logic signed [W-1:0]  v_q   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0]       rin, r2, mx;
    logic [QB-1:0]       qin, xin;
    logic [W:0]          min;
    logic                nin, ge;
    logic signed [W-1:0] vin;

    if (k == 0) begin : g_first
      assign rin = {3'b000, a_i[W-1:1]};
      assign qin = '0;
      assign xin = {a_i[0], {UNIT_FRAC{1'b0}}};
      assign min = m_i;
      assign nin = neg_i;
      assign vin = v_i;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = q_q[k-1];
      assign xin = x_q[k-1];
      assign min = m_q[k-1];
      assign nin = neg_q[k-1];
      assign vin = v_q[k-1];
    end

    assign r2 = {rin[RW-2:0], xin[QB-1]};
    assign mx = {1'b0, min};
    assign ge = (r2 >= mx);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (r2 - mx) : r2;
        q_q[k]   <= {qin[QB-2:0], ge};
        x_q[k]   <= {xin[QB-2:0], 1'b0};
        m_q[k]   <= min;
        neg_q[k] <= nin;
        v_q[k]   <= vin;
      end
    end
  end

  logic signed [UB-1:0]   qs, u_q, u2_q;
  logic signed [W-1:0]    vu_q, v2_q;
  logic signed [W+UB-1:0] prod_q;

  assign qs = $signed({1'b0, q_q[QB-1]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q    <= neg_q[QB-1] ? -qs : qs;
      vu_q   <= v_q[QB-1];
      prod_q <= vu_q * u_q;
      u2_q   <= u_q;
      v2_q   <= vu_q;
    end
  end

  assign u_o    = u2_q;
  assign v_o    = v2_q;
  assign prod_o = prod_q;

endmodule

### sv/pwr_lane_fin.sv
`timescale 1ns / 1ps
module pwr_lane_fin
  import pwr_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [W+UB+2-UNIT_FRAC-1:0]    un_i,
  input  logic signed [UB-1:0]                  u_i,
  input  logic signed [W-1:0]                   v_i,
  input  pwr_ctl_t                              ctl_i,
  input  logic [COEF_W-1:0]                     an_i,
  input  logic [COEF_W-1:0]                     at_i,
  output logic [W-1:0]                          res_o,
  output logic                                  clip_o,
  output pwr_ctl_t                              ctl_o
);

  localparam int UNW  = W + UB + 2 - UNIT_FRAC;
  localparam int PMW  = UNW + UB;
  localparam int PW   = PMW - UNIT_FRAC;
  localparam int CW   = COEF_W + 1;
  localparam int SUMW = PW + CW + 2;
  localparam int RW   = SUMW - COEF_FRAC;

  logic signed [PMW-1:0] pm;
  logic signed [PW-1:0]  p1_q;
  logic signed [W-1:0]   v1_q, v2_q;
  pwr_ctl_t              ctl1_q, ctl2_q, ctl3_q;

  assign pm = un_i * u_i;

  logic signed [PW:0]     t;
  logic signed [CW-1:0]   cn, at;
  logic signed [SUMW-1:0] cp, ap, cp_q, ap_q, sum;
  logic signed [RW-1:0]   r;
  logic [W-1:0]           res_d, res_q;
  logic                   clip_d, clip_q;

  assign t  = (PW + 1)'(v1_q) - (PW + 1)'(p1_q);
  assign cn = ctl1_q.into ? -$signed({1'b0, an_i}) : COEF_ONE_S;
  assign at = $signed({1'b0, at_i});
  assign cp = cn * p1_q;
  assign ap = at * t;

  assign sum = cp_q + ap_q;
  assign r   = sum[SUMW-1:COEF_FRAC];

  always_comb begin
    res_d  = r[W-1:0];
    clip_d = 1'b0;
    if (ctl2_q.zero) begin
      res_d = v2_q;
    end else if (r[RW-1] && !(&r[RW-1:W-1])) begin
      res_d  = {1'b1, {(W-1){1'b0}}};
      clip_d = 1'b1;
    end else if (!r[RW-1] && (|r[RW-1:W-1])) begin
      res_d  = {1'b0, {(W-1){1'b1}}};
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= pm[PMW-1:UNIT_FRAC];
      v1_q   <= v_i;
      ctl1_q <= ctl_i;
      cp_q   <= cp;
      ap_q   <= ap;
      v2_q   <= v1_q;
      ctl2_q <= ctl1_q;
      res_q  <= res_d;
      clip_q <= clip_d;
      ctl3_q <= ctl2_q;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;
  assign ctl_o  = ctl3_q;

endmodule

### sv/particle_wall_rebound.sv
// throughput: one item per cycle, the square root and the three lane dividers are
// fully pipelined with one result bit per stage
// the whole pipeline holds while the output item waits and tready is low
// reset clears the valid bits and sets both coefficients to 1.0
`timescale 1ns / 1ps
module particle_wall_rebound
  import pwr_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // vel_x, vel_y, vel_z, wall_nx, wall_ny, wall_nz
  input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // new_vel_x, new_vel_y, new_vel_z
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // moving_into_wall, zero_normal, clipped
  output logic [2:0]                             m_axis_tuser,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_idx_i,
  input  logic [COEF_W-1:0]                      cfg_wdata_i
);

`include "assert_macros.svh"

  localparam int W    = DATA_WIDTH;
  localparam int OTW  = ((3 * W + 7) / 8) * 8;
  localparam int SQL  = W + 1;
  localparam int DVL  = QB + 2;
  localparam int LAT  = 3 + SQL + DVL + 1 + 3;
  localparam int SBW  = 6 * W + 4;
  localparam int DW   = W + UB + 2;
  localparam int UNW  = DW - UNIT_FRAC;

  logic             en;
  logic [LAT-1:0]   vld_q;
  logic [COEF_W-1:0] an_q, at_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      an_q <= COEF_ONE;
      at_q <= COEF_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NORMAL:     an_q <= cfg_wdata_i;
        CFG_TANGENTIAL: at_q <= cfg_wdata_i;
        default:        an_q <= an_q;
      endcase
    end
  end

  // front end: magnitudes, squares, sum of squares
  logic signed [W-1:0] v_in [3], n_in [3];
  logic signed [W-1:0] v1_q [3], v2_q [3], v3_q [3];
  logic [W-1:0]        a1_q [3], a2_q [3], a3_q [3];
  logic                ng1_q [3], ng2_q [3], ng3_q [3];
  logic [2*W-1:0]      sq2_q [3];
  logic [2*W+1:0]      s3_q;
  logic                zero3_q;

  for (genvar i = 0; i < 3; i++) begin : g_in
    assign v_in[i] = s_axis_tdata[i*W +: W];
    assign n_in[i] = s_axis_tdata[(3+i)*W +: W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_q[i]  <= v_in[i];
        ng1_q[i] <= n_in[i][W-1];
        a1_q[i]  <= n_in[i][W-1] ? W'(-n_in[i]) : n_in[i];
        v2_q[i]  <= v1_q[i];
        ng2_q[i] <= ng1_q[i];
        a2_q[i]  <= a1_q[i];
        sq2_q[i] <= (2*W)'(a1_q[i]) * (2*W)'(a1_q[i]);
        v3_q[i]  <= v2_q[i];
        ng3_q[i] <= ng2_q[i];
        a3_q[i]  <= a2_q[i];
      end
      s3_q    <= (2*W+2)'(sq2_q[0]) + (2*W+2)'(sq2_q[1]) + (2*W+2)'(sq2_q[2]);
      zero3_q <= (a2_q[0] == '0) && (a2_q[1] == '0) && (a2_q[2] == '0);
    end
  end

  logic [W:0] m_root;

  pwr_sqrt #(.W(W)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s3_q),
    .root_o (m_root)
  );

  logic [SBW-1:0] sb3, sb_q [SQL];

  assign sb3 = {zero3_q, ng3_q[2], ng3_q[1], ng3_q[0], a3_q[2], a3_q[1], a3_q[0],
                v3_q[2], v3_q[1], v3_q[0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb3;
      for (int k = 1; k < SQL; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // three lanes: unit normal component and its velocity product
  logic signed [UB-1:0]   u4 [3];
  logic signed [W-1:0]    v4 [3];
  logic signed [W+UB-1:0] pr4 [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    pwr_lane_div #(.W(W)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .a_i    (sb_q[SQL-1][(3+i)*W +: W]),
      .neg_i  (sb_q[SQL-1][6*W+i]),
      .v_i    (sb_q[SQL-1][i*W +: W]),
      .m_i    (m_root),
      .u_o    (u4[i]),
      .v_o    (v4[i]),
      .prod_o (pr4[i])
    );
  end

  logic zd_q [DVL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      zd_q[0] <= sb_q[SQL-1][SBW-1];
      for (int k = 1; k < DVL; k++) zd_q[k] <= zd_q[k-1];
    end
  end

  // merge: dot product and normal speed
  logic signed [DW-1:0]  d;
  logic signed [UNW-1:0] un5_q;
  logic signed [UB-1:0]  u5_q [3];
  logic signed [W-1:0]   v5_q [3];
  pwr_ctl_t              ctl5_q;

  assign d = DW'(pr4[0]) + DW'(pr4[1]) + DW'(pr4[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      un5_q       <= d[DW-1:UNIT_FRAC];
      ctl5_q.into <= !zd_q[DVL-1] && !d[DW-1] && (d != '0);
      ctl5_q.zero <= zd_q[DVL-1];
      for (int i = 0; i < 3; i++) begin
        u5_q[i] <= u4[i];
        v5_q[i] <= v4[i];
      end
    end
  end

  logic [W-1:0] res [3];
  logic         clip [3];
  pwr_ctl_t     ctl_out [3];

  for (genvar i = 0; i < 3; i++) begin : g_fin
    pwr_lane_fin #(.W(W)) u_fin (
      .clk_i  (clk_i),
      .en_i   (en),
      .un_i   (un5_q),
      .u_i    (u5_q[i]),
      .v_i    (v5_q[i]),
      .ctl_i  (ctl5_q),
      .an_i   (an_q),
      .at_i   (at_q),
      .res_o  (res[i]),
      .clip_o (clip[i]),
      .ctl_o  (ctl_out[i])
    );
  end

  assign m_axis_tdata = OTW'({res[2], res[1], res[0]});
  assign m_axis_tuser = {clip[0] || clip[1] || clip[2], ctl_out[0].zero, ctl_out[0].into};

  `PWR_ASSERT(a_hold, clk_i, rst_ni, !en |=> $stable(vld_q))
  `PWR_ASSERT(a_enter, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> vld_q[0])
  `PWR_ASSERT(a_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser == 3'b010)
  `PWR_ASSERT(a_cfg, clk_i, rst_ni, cfg_we_i && cfg_idx_i == CFG_NORMAL |=> an_q == $past(cfg_wdata_i))

endmodule
